### rtl/core/bmsb_pkg.sv
// bmsb_pkg: shared types and constants for the masked span blitter
// holds word sizes, command codes and the request/response word structs
// no dependencies
package bmsb_pkg;

	localparam int WORD_BITS = 32;
	localparam int MAX_SPAN  = 1024;
	localparam int POS_W     = $clog2(WORD_BITS);
	localparam int CNT_W     = $clog2(WORD_BITS + 1);
	localparam int SPAN_W    = $clog2(MAX_SPAN + 1);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	typedef enum logic {
		MODE_COLOR = 1'b0,
		MODE_MASK  = 1'b1
	} plane_mode_t;

	typedef struct packed {
		cmd_t                 command;
		plane_mode_t          plane_mode;
		logic [4:0]           dest_bit_start;
		logic [4:0]           src_bit_start;
		logic [10:0]          span_bits;
		logic [31:0]          dest_word;
		logic [31:0]          color_word;
		logic [31:0]          mask_word;
	} req_word_t;

	typedef struct packed {
		logic [31:0] new_dest_word;
		logic        last_word;
	} rsp_word_t;

endpackage

### rtl/core/bitplane_masked_span_blit_core.sv
// bitplane_masked_span_blit_core: masked span blitter for one scanline of a 1-bit plane
// depends on bmsb_pkg and bmsb_funnel
//
// usage: words enter on req (valid/ready) and leave on rsp (valid/ready).
// a start word (command CMD_START) latches mode, bit starts and span length and
// primes the source funnel with its colour and mask words; it gives no response.
// each data word carries a destination word plus the next colour and mask words
// and, while a span is running, gives one response with the updated destination
// word; last_word marks the final word of the span. data words while idle are
// dropped without a response.
// a data word is taken into the input register; once the output register is free,
// its response word is loaded there and rsp_valid rises. throughput: one word per
// cycle while rsp is not stalled, set by the single pass through the funnel
// shifters and span mask between the two registers.
// a stalled rsp holds its word in the output register; as soon as the input
// register holds a data word of a running span behind it, req_ready drops in the
// same cycle, so a stall holds req off for as long as it lasts.
// reset: span idle, held source words and counters cleared, no words in flight.
module bitplane_masked_span_blit_core
	import bmsb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	// input stage
	logic      valid_s1;
	req_word_t req_s1;

	// span state
	logic [WORD_BITS-1:0] held_color_q;
	logic [WORD_BITS-1:0] held_mask_q;
	logic [SPAN_W-1:0]    bits_left_q;
	logic [POS_W-1:0]     align_shift_q;
	logic [POS_W-1:0]     first_bit_pos_q;
	plane_mode_t          mode_q;
	logic                 span_active_q;

	// output stage
	logic      rsp_valid_q;
	rsp_word_t rsp_q;

	logic                 is_start;
	logic                 makes_rsp;
	logic                 out_free;
	logic                 advance;
	logic [WORD_BITS-1:0] color_al;
	logic [WORD_BITS-1:0] mask_al;
	logic [CNT_W-1:0]     room;
	logic [CNT_W-1:0]     count;
	logic [WORD_BITS:0]   ones;
	logic [WORD_BITS-1:0] span_mask;
	logic [WORD_BITS-1:0] blended;
	logic [SPAN_W-1:0]    bits_next;
	logic [SPAN_W-1:0]    span_sat;

	assign is_start  = (req_s1.command == CMD_START);
	assign makes_rsp = valid_s1 && !is_start && span_active_q;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign advance   = valid_s1 && (!makes_rsp || out_free);
	assign req_ready = !valid_s1 || advance;

	bmsb_funnel u_color_funnel (
		.held     (held_color_q),
		.incoming (req_s1.color_word),
		.shift    (align_shift_q),
		.aligned  (color_al)
	);

	bmsb_funnel u_mask_funnel (
		.held     (held_mask_q),
		.incoming (req_s1.mask_word),
		.shift    (align_shift_q),
		.aligned  (mask_al)
	);

	// span bits within this destination word
	always_comb begin
		room = CNT_W'(WORD_BITS) - CNT_W'(first_bit_pos_q);
		if (SPAN_W'(room) > bits_left_q) begin
			count = CNT_W'(bits_left_q);
		end else begin
			count = room;
		end
		ones      = ({{WORD_BITS{1'b0}}, 1'b1} << count) - 1'b1;
		span_mask = ones[WORD_BITS-1:0] << first_bit_pos_q;
		blended   = req_s1.dest_word & mask_al;
		if (mode_q == MODE_COLOR) begin
			blended = blended | color_al;
		end
		bits_next = bits_left_q - SPAN_W'(count);
		if (req_s1.span_bits > SPAN_W'(MAX_SPAN)) begin
			span_sat = SPAN_W'(MAX_SPAN);
		end else begin
			span_sat = req_s1.span_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_color_q    <= '0;
			held_mask_q     <= '0;
			bits_left_q     <= '0;
			align_shift_q   <= '0;
			first_bit_pos_q <= '0;
			mode_q          <= MODE_COLOR;
			span_active_q   <= 1'b0;
		end else if (advance) begin
			if (is_start) begin
				held_color_q    <= req_s1.color_word;
				held_mask_q     <= req_s1.mask_word;
				bits_left_q     <= span_sat;
				align_shift_q   <= req_s1.src_bit_start - req_s1.dest_bit_start;
				first_bit_pos_q <= req_s1.dest_bit_start;
				mode_q          <= req_s1.plane_mode;
				span_active_q   <= (span_sat != '0);
			end else if (span_active_q) begin
				held_color_q    <= req_s1.color_word;
				held_mask_q     <= req_s1.mask_word;
				bits_left_q     <= bits_next;
				first_bit_pos_q <= '0;
				span_active_q   <= (bits_next != '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= advance && makes_rsp;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && makes_rsp) begin
			rsp_q.new_dest_word <= (req_s1.dest_word & ~span_mask) | (blended & span_mask);
			rsp_q.last_word     <= (bits_next == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_active_matches_count: assert property (
		@(posedge clk) disable iff (!arst_n)
		span_active_q == (bits_left_q != '0)
	) else $error("span active flag disagrees with remaining bit count");

	a_span_bounded: assert property (
		@(posedge clk) disable iff (!arst_n)
		bits_left_q <= SPAN_W'(MAX_SPAN)
	) else $error("remaining bit count above maximum span");

	a_last_ends_span: assert property (
		@(posedge clk) disable iff (!arst_n)
		(advance && makes_rsp && (bits_next == '0)) |=> !span_active_q
	) else $error("span still active after its last word");

	a_data_realigns: assert property (
		@(posedge clk) disable iff (!arst_n)
		(advance && makes_rsp) |=> (first_bit_pos_q == '0)
	) else $error("first bit position not cleared after a data word");
`endif

endmodule

### rtl/core/bmsb_funnel.sv
// bmsb_funnel: funnel shifter joining the held source word and the incoming one
// depends on bmsb_pkg
module bmsb_funnel
	import bmsb_pkg::*;
(
	input  logic [WORD_BITS-1:0] held,
	input  logic [WORD_BITS-1:0] incoming,
	input  logic [POS_W-1:0]     shift,
	output logic [WORD_BITS-1:0] aligned
);

	logic [2*WORD_BITS-1:0] window;

	// incoming word sits above the held word, shifted down by the alignment
	assign window  = {incoming, held} >> shift;
	assign aligned = window[WORD_BITS-1:0];

endmodule
